FILE: rtl/core/uartrb_pkg.sv
// Package for the UART ring-buffer front end: event codes, status codes,
// the control bundle between sequencer and top level, and the hex digit helper.
// No dependencies.
package uartrb_pkg;

  // Event codes on op
  localparam logic [2:0] OP_RX_BYTE  = 3'd0;
  localparam logic [2:0] OP_HOST_RD  = 3'd1;
  localparam logic [2:0] OP_LINE_RDY = 3'd2;
  localparam logic [2:0] OP_HOST_TX  = 3'd3;
  localparam logic [2:0] OP_HOST_HEX = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TX_FULL    = 3'd1;
  localparam logic [2:0] ST_RX_EMPTY   = 3'd2;
  localparam logic [2:0] ST_RX_OVERRUN = 3'd3;
  localparam logic [2:0] ST_ECHO_DROP  = 3'd4;

  // ASCII bases for hex digits
  localparam logic [7:0] HEX_ALPHA = 8'h40;
  localparam logic [7:0] HEX_NUM   = 8'h30;

  // Default ring depths
  localparam int DEF_RX_DEPTH = 256;
  localparam int DEF_TX_DEPTH = 256;

  // Control bundle from the sequencer to the storage/result side
  typedef struct packed {
    logic       fire;          // transaction completes this cycle
    logic       rx_we;
    logic [7:0] rx_wdata;
    logic       rx_re;
    logic       tx_we;
    logic [7:0] tx_wdata;
    logic       tx_re;
    logic       line_valid;
    logic       read_valid;
    logic [2:0] status;
    logic       rx_pending;
    logic       tx_irq_enabled;
  } ctl_t;

  // Uppercase ASCII hex digit of one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib > 4'd9) begin
      res = 8'(nib - 4'd9) | HEX_ALPHA;
    end else begin
      res = 8'(nib) | HEX_NUM;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/uart_ring_buffers_with_echo.sv
// Top level of the UART ring-buffer front end with receive echo.
// Holds the two byte stores and the result register; uses uartrb_pkg
// and uartrb_ctrl.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------
//   event in | start, busy (accept: start & !busy) | op, data
//   result   | done (one cycle, no stall)| line_valid, line_byte, read_valid,
//            |                           | read_byte, status, rx_pending,
//            |                           | tx_irq_enabled
//
// An accepted transaction passes the input register in uartrb_ctrl and then
// the result register before it shows on done. A hex send with room for both
// digits writes its digits one after the other (one store write port, two digits)
// and raises busy while the first digit is written; every other event, and a hex
// send without room, holds nothing and a new event may follow at once.
// Reset is synchronous on rst and clears pointers, flags, input valid, hex phase
// and done; the stores are not cleared. The receiver cannot stall, so done is never held.
module uart_ring_buffers_with_echo
  import uartrb_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic [7:0] data,
  output logic       done,
  output logic       line_valid,
  output logic [7:0] line_byte,
  output logic       read_valid,
  output logic [7:0] read_byte,
  output logic [2:0] status,
  output logic       rx_pending,
  output logic       tx_irq_enabled
);

  localparam int RX_AW = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1;

  ctl_t             ctl;
  logic [RX_AW-1:0] rx_waddr, rx_raddr;
  logic [TX_AW-1:0] tx_waddr, tx_raddr;

  uartrb_ctrl #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .op      (op),
    .data    (data),
    .busy    (busy),
    .ctl     (ctl),
    .rx_waddr(rx_waddr),
    .rx_raddr(rx_raddr),
    .tx_waddr(tx_waddr),
    .tx_raddr(tx_raddr)
  );

  // Byte stores, one write and one registered read each
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rd, tx_rd;

  always_ff @(posedge clk) begin
    if (ctl.rx_we) begin
      rx_mem[rx_waddr] <= ctl.rx_wdata;
    end
    if (ctl.rx_re) begin
      rx_rd <= rx_mem[rx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tx_we) begin
      tx_mem[tx_waddr] <= ctl.tx_wdata;
    end
    if (ctl.tx_re) begin
      tx_rd <= tx_mem[tx_raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.fire;
    end
    if (ctl.fire) begin
      line_valid     <= ctl.line_valid;
      read_valid     <= ctl.read_valid;
      status         <= ctl.status;
      rx_pending     <= ctl.rx_pending;
      tx_irq_enabled <= ctl.tx_irq_enabled;
    end
  end

  assign line_byte = line_valid ? tx_rd : 8'h00;
  assign read_byte = read_valid ? rx_rd : 8'h00;

  // Checks
  a_one_pop: assert property (@(posedge clk) disable iff (rst)
    done |-> !(line_valid && read_valid))
    else $error("line and read pops in one transaction");

  a_hex_two: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("hex send held more than two cycles");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op != OP_HOST_HEX)) |-> ##2 done)
    else $error("result missing two cycles after accept");

  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_RX_EMPTY)) |-> (!read_valid && !rx_pending))
    else $error("empty read returned data or left flag set");

endmodule

FILE: rtl/core/uartrb_ctrl.sv
// Sequencer for the UART ring buffers: input register, ring pointers,
// flags, and the per-event decision logic. Uses uartrb_pkg.
// Memory accesses are issued to the top level through ctl_t.
module uartrb_ctrl
  import uartrb_pkg::*;
#(
  parameter int RX_DEPTH = DEF_RX_DEPTH,
  parameter int TX_DEPTH = DEF_TX_DEPTH,
  localparam int RX_AW = (RX_DEPTH > 2) ? $clog2(RX_DEPTH) : 1,
  localparam int TX_AW = (TX_DEPTH > 2) ? $clog2(TX_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0]       op,
  input  logic [7:0]       data,
  output logic             busy,
  output ctl_t             ctl,
  output logic [RX_AW-1:0] rx_waddr,
  output logic [RX_AW-1:0] rx_raddr,
  output logic [TX_AW-1:0] tx_waddr,
  output logic [TX_AW-1:0] tx_raddr
);

  // Ring index increments modulo depth
  function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
    return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
  endfunction

  function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
    return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
  endfunction

  // Input register and hex phase
  logic       s_valid;
  logic [2:0] s_op;
  logic [7:0] s_data;
  logic       phase, phase_next;

  // Ring state
  logic [RX_AW-1:0] rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [TX_AW-1:0] tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic             rx_flag, rx_flag_next;
  logic             irq_on, irq_on_next;

  logic [RX_AW-1:0] rx_nh, rx_nt;
  logic [TX_AW-1:0] tx_nh, tx_nh2, tx_nt;
  logic             rx_full, tx_full, hex_room;

  assign rx_nh    = rx_inc(rx_head);
  assign rx_nt    = rx_inc(rx_tail);
  assign tx_nh    = tx_inc(tx_head);
  assign tx_nh2   = tx_inc(tx_nh);
  assign tx_nt    = tx_inc(tx_tail);
  assign rx_full  = (rx_nh == rx_tail);
  assign tx_full  = (tx_nh == tx_tail);
  assign hex_room = !tx_full && (tx_nh2 != tx_tail);

  // A hex send with room for both digits holds the input register for its second digit
  assign busy = s_valid && (s_op == OP_HOST_HEX) && !phase && hex_room;

  assign rx_waddr = rx_nh;
  assign rx_raddr = rx_nt;
  assign tx_waddr = tx_nh;
  assign tx_raddr = tx_nt;

  // Event decode
  always_comb begin
    rx_head_next = rx_head;
    rx_tail_next = rx_tail;
    tx_head_next = tx_head;
    tx_tail_next = tx_tail;
    rx_flag_next = rx_flag;
    irq_on_next  = irq_on;
    phase_next   = 1'b0;
    ctl          = '0;
    ctl.rx_wdata = s_data;
    ctl.tx_wdata = s_data;
    ctl.status   = ST_OK;
    if (s_valid) begin
      case (s_op)
        OP_RX_BYTE: begin
          if (rx_full) begin
            ctl.status = ST_RX_OVERRUN;
          end else begin
            ctl.rx_we    = 1'b1;
            rx_head_next = rx_nh;
            if (tx_full) begin
              ctl.status = ST_ECHO_DROP;
            end else begin
              ctl.tx_we    = 1'b1;
              tx_head_next = tx_nh;
              irq_on_next  = 1'b1;
            end
          end
          rx_flag_next = 1'b1;
        end
        OP_HOST_RD: begin
          if (rx_head == rx_tail) begin
            ctl.status = ST_RX_EMPTY;
          end else begin
            ctl.rx_re      = 1'b1;
            ctl.read_valid = 1'b1;
            rx_tail_next   = rx_nt;
            if (rx_head == rx_nt) begin
              rx_flag_next = 1'b0;
            end
          end
        end
        OP_LINE_RDY: begin
          if (tx_head != tx_tail) begin
            ctl.tx_re      = 1'b1;
            ctl.line_valid = 1'b1;
            tx_tail_next   = tx_nt;
          end else begin
            irq_on_next = 1'b0;
          end
        end
        OP_HOST_TX: begin
          if (tx_full) begin
            ctl.status = ST_TX_FULL;
          end else begin
            ctl.tx_we    = 1'b1;
            tx_head_next = tx_nh;
            irq_on_next  = 1'b1;
          end
        end
        OP_HOST_HEX: begin
          if (phase) begin
            // low digit; room was checked in the first phase
            ctl.tx_we    = 1'b1;
            ctl.tx_wdata = hex_digit(s_data[3:0]);
            tx_head_next = tx_nh;
            irq_on_next  = 1'b1;
          end else if (!hex_room) begin
            ctl.status = ST_TX_FULL;
          end else begin
            ctl.tx_we    = 1'b1;
            ctl.tx_wdata = hex_digit(s_data[7:4]);
            tx_head_next = tx_nh;
            irq_on_next  = 1'b1;
            phase_next   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    ctl.fire           = s_valid && !busy;
    ctl.rx_pending     = rx_flag_next;
    ctl.tx_irq_enabled = irq_on_next;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      phase   <= 1'b0;
    end else begin
      phase <= phase_next;
      if (!busy) begin
        s_valid <= start;
      end
    end
    if (start && !busy) begin
      s_op   <= op;
      s_data <= data;
    end
  end

  // Ring pointers and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head <= '0;
      rx_tail <= '0;
      tx_head <= '0;
      tx_tail <= '0;
      rx_flag <= 1'b0;
      irq_on  <= 1'b0;
    end else begin
      rx_head <= rx_head_next;
      rx_tail <= rx_tail_next;
      tx_head <= tx_head_next;
      tx_tail <= tx_tail_next;
      rx_flag <= rx_flag_next;
      irq_on  <= irq_on_next;
    end
  end

endmodule
